// ===== rtl/core/strp_pkg.sv =====
// Package with shared types, codes and sizes for the sorted table rank product block.
`timescale 1ns / 1ps

package strp_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = 9;
    localparam int VALUE_W     = 32;
    localparam int BENEFIT_W   = 15;
    localparam int OUT_DATA_W  = 40;

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_QUERY = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic [1:0] STATUS_LOADED = 2'd0;
    localparam logic [1:0] STATUS_FULL   = 2'd1;
    localparam logic [1:0] STATUS_ANSWER = 2'd2;
    localparam logic [1:0] STATUS_CLEARD = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_CLEAR,
        ST_SCAN,
        ST_MUL,
        ST_ANSWER
    } state_t;

    typedef struct packed {
        logic       capture;
        logic       do_load;
        logic       do_clear;
        logic       scan_start;
        logic       scan_step;
        logic       mul_load;
        logic       out_load;
        logic [1:0] out_status;
    } ctrl_cmd_t;

    typedef struct packed {
        logic table_full;
        logic scan_done;
        logic out_free;
    } dp_stat_t;

endpackage

// ===== rtl/core/strp_ctrl.sv =====
// Controller state machine that sequences loads, clears and query scans.
`timescale 1ns / 1ps

module strp_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [1:0]          in_cmd,
    output logic                in_ready,
    input  strp_pkg::dp_stat_t  stat,
    output strp_pkg::ctrl_cmd_t cmd
);

    strp_pkg::state_t state_reg;
    strp_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= strp_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        in_ready       = 1'b0;
        cmd            = '0;
        cmd.out_status = strp_pkg::STATUS_LOADED;
        unique case (state_reg)
            strp_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    unique case (in_cmd)
                        strp_pkg::CMD_LOAD:  state_next = strp_pkg::ST_LOAD;
                        strp_pkg::CMD_QUERY:
                        begin
                            cmd.scan_start = 1'b1;
                            state_next     = strp_pkg::ST_SCAN;
                        end
                        strp_pkg::CMD_CLEAR: state_next = strp_pkg::ST_CLEAR;
                        default:             state_next = strp_pkg::ST_IDLE;
                    endcase
                end
            end
            strp_pkg::ST_LOAD:
            begin
                if (stat.out_free)
                begin
                    cmd.do_load    = 1'b1;
                    cmd.out_load   = 1'b1;
                    cmd.out_status = stat.table_full ? strp_pkg::STATUS_FULL
                                                     : strp_pkg::STATUS_LOADED;
                    state_next     = strp_pkg::ST_IDLE;
                end
            end
            strp_pkg::ST_CLEAR:
            begin
                if (stat.out_free)
                begin
                    cmd.do_clear   = 1'b1;
                    cmd.out_load   = 1'b1;
                    cmd.out_status = strp_pkg::STATUS_CLEARD;
                    state_next     = strp_pkg::ST_IDLE;
                end
            end
            strp_pkg::ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = strp_pkg::ST_MUL;
                end
            end
            strp_pkg::ST_MUL:
            begin
                cmd.mul_load = 1'b1;
                state_next   = strp_pkg::ST_ANSWER;
            end
            strp_pkg::ST_ANSWER:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_status = strp_pkg::STATUS_ANSWER;
                    state_next     = strp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = strp_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/strp_datapath.sv =====
// Datapath with the table memory, entry count, scan counters, multiplier and output register.
`timescale 1ns / 1ps

module strp_datapath
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  strp_pkg::ctrl_cmd_t                 cmd,
    output strp_pkg::dp_stat_t                  stat,
    input  logic signed [strp_pkg::VALUE_W-1:0] in_value,
    input  logic                                in_last,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [1:0]                          out_status,
    output logic [strp_pkg::CNT_W-1:0]          out_below,
    output logic [strp_pkg::CNT_W-1:0]          out_above,
    output logic [strp_pkg::BENEFIT_W-1:0]      out_benefit,
    output logic                                out_last
);

    logic signed [strp_pkg::VALUE_W-1:0] table_mem [strp_pkg::TABLE_DEPTH];

    logic signed [strp_pkg::VALUE_W-1:0] value_reg;
    logic                                last_reg;
    logic [strp_pkg::CNT_W-1:0]          count_reg;
    logic [strp_pkg::CNT_W-1:0]          idx_reg;
    logic                                pend_reg;
    logic signed [strp_pkg::VALUE_W-1:0] rd_data_reg;
    logic [strp_pkg::CNT_W-1:0]          below_reg;
    logic [strp_pkg::CNT_W-1:0]          above_reg;
    logic [2*strp_pkg::CNT_W-1:0]        prod_reg;
    logic                                out_valid_reg;
    logic [1:0]                          out_status_reg;
    logic [strp_pkg::CNT_W-1:0]          out_below_reg;
    logic [strp_pkg::CNT_W-1:0]          out_above_reg;
    logic [strp_pkg::BENEFIT_W-1:0]      out_benefit_reg;
    logic                                out_last_reg;

    logic table_full;
    logic is_answer;

    assign table_full = (count_reg == strp_pkg::CNT_W'(strp_pkg::TABLE_DEPTH));
    assign is_answer  = (cmd.out_status == strp_pkg::STATUS_ANSWER);

    assign stat.table_full = table_full;
    assign stat.scan_done  = (idx_reg == count_reg) && !pend_reg;
    assign stat.out_free   = !out_valid_reg || out_ready;

    // Table memory: one write port for loads, one registered read port for the scan.
    always_ff @(posedge clk)
    begin
        if (cmd.do_load && !table_full)
        begin
            table_mem[count_reg[strp_pkg::ADDR_W-1:0]] <= value_reg;
        end
        if (cmd.scan_step && (idx_reg < count_reg))
        begin
            rd_data_reg <= table_mem[idx_reg[strp_pkg::ADDR_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            value_reg <= in_value;
            last_reg  <= in_last;
        end
        if (cmd.mul_load)
        begin
            prod_reg <= below_reg * above_reg;
        end
        if (cmd.out_load)
        begin
            out_status_reg  <= cmd.out_status;
            out_below_reg   <= is_answer ? below_reg : '0;
            out_above_reg   <= is_answer ? above_reg : '0;
            out_benefit_reg <= is_answer ? prod_reg[strp_pkg::BENEFIT_W-1:0] : '0;
            out_last_reg    <= is_answer ? last_reg : 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            below_reg     <= '0;
            above_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.do_clear)
            begin
                count_reg <= '0;
            end
            else if (cmd.do_load && !table_full)
            begin
                count_reg <= count_reg + 1'b1;
            end

            if (cmd.scan_start)
            begin
                idx_reg   <= '0;
                pend_reg  <= 1'b0;
                below_reg <= '0;
                above_reg <= '0;
            end
            else if (cmd.scan_step)
            begin
                if (idx_reg < count_reg)
                begin
                    idx_reg  <= idx_reg + 1'b1;
                    pend_reg <= 1'b1;
                end
                else
                begin
                    pend_reg <= 1'b0;
                end
                if (pend_reg)
                begin
                    if (rd_data_reg < value_reg)
                    begin
                        below_reg <= below_reg + 1'b1;
                    end
                    else if (rd_data_reg > value_reg)
                    begin
                        above_reg <= above_reg + 1'b1;
                    end
                end
            end

            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_status  = out_status_reg;
    assign out_below   = out_below_reg;
    assign out_above   = out_above_reg;
    assign out_benefit = out_benefit_reg;
    assign out_last    = out_last_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= strp_pkg::CNT_W'(strp_pkg::TABLE_DEPTH))
        else $error("entry count exceeds table depth");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_step |-> (idx_reg <= count_reg))
        else $error("scan index passed the entry count");

    a_counts_sum: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, below_reg} + {1'b0, above_reg}) <= {1'b0, idx_reg})
        else $error("below and above counts exceed entries scanned");

    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("result written over one not yet transferred");

endmodule

// ===== rtl/core/sorted_table_rank_product.sv =====
// Top level of the sorted table rank product block.
// Usage: the slave stream carries one command per transfer. s_tuser holds the command
// (load entry, query, clear), s_tdata the signed 32-bit value and s_tlast the final
// flag of a query. Every load, query and clear gives one result transfer on the master
// stream; an unused command code gives none. m_tuser holds the status, m_tlast echoes
// the final flag on a query answer, and m_tdata holds below count, above count and
// their product.
// A load or clear is accepted in the idle state and done in the LOAD or CLEAR state, which
// waits for a free output register, writes the result there and returns to idle.
// A query scans every stored entry through the table's single read port, one entry
// per cycle, then forms the product in the MUL state, and in the ANSWER state it waits
// for a free output register before it writes the result there.
// One item is worked on at a time; s_tready is high only while the block is idle,
// and a new item may be accepted while the previous result waits in the output register.
// Reset clears the entry count, so the table starts empty; the memory contents are
// not cleared. When the receiver stalls, the result stays in the output register and
// the block holds the next finished result until that register is free.
`timescale 1ns / 1ps

module sorted_table_rank_product
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [31:0]                     s_tdata,  // value[31:0]
    input  logic                            s_tlast,
    input  logic [1:0]                      s_tuser,  // cmd[1:0]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // below_count[8:0], above_count[17:9], benefit[32:18], zero
    output logic [strp_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic                            m_tlast,
    output logic [1:0]                      m_tuser   // status[1:0]
);

    strp_pkg::ctrl_cmd_t                cmd;
    strp_pkg::dp_stat_t                 stat;
    logic [strp_pkg::CNT_W-1:0]         below;
    logic [strp_pkg::CNT_W-1:0]         above;
    logic [strp_pkg::BENEFIT_W-1:0]     benefit;

    strp_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_cmd   (s_tuser),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    strp_datapath u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .in_value    (s_tdata),
        .in_last     (s_tlast),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_status  (m_tuser),
        .out_below   (below),
        .out_above   (above),
        .out_benefit (benefit),
        .out_last    (m_tlast)
    );

    assign m_tdata = {7'd0, benefit, above, below};

endmodule

// ===== verif/sorted_table_rank_product_tb.sv =====
// Self-checking testbench for the sorted table rank product block.
`timescale 1ns / 1ps

module sorted_table_rank_product_tb;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT     = 4000000;
    localparam int DRAIN_CYCLES    = 300;
    localparam int ITEMS_PER_PHASE = 320;
    localparam int LONG_HOLD       = 600;

    typedef struct packed {
        logic [1:0]                     status;
        logic [strp_pkg::CNT_W-1:0]     below;
        logic [strp_pkg::CNT_W-1:0]     above;
        logic [strp_pkg::BENEFIT_W-1:0] benefit;
        logic                           batch_end;
    } rank_answer_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        s_tlast;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        m_tlast;
    logic [1:0]  m_tuser;

    int           table_vals [strp_pkg::TABLE_DEPTH];
    int unsigned  table_len = 0;
    rank_answer_t pending_answers [$];
    int           error_count = 0;
    int           items_sent = 0;
    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;
    int           hold_request = 0;
    longint       cycle_count = 0;

    sorted_table_rank_product dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
        end
        $display("sorted_table_rank_product_tb: FAIL");
        $finish;
    end

    function automatic bit predict_answer(input logic [1:0] cmd, input logic [31:0] value,
                                          input logic fin, output rank_answer_t ans);
        int          qv;
        int unsigned below;
        int unsigned above;
        int unsigned k;
        qv    = value;
        below = 0;
        above = 0;
        ans   = '0;
        case (cmd)
            strp_pkg::CMD_LOAD:
            begin
                if (table_len >= strp_pkg::TABLE_DEPTH)
                begin
                    ans.status = strp_pkg::STATUS_FULL;
                end
                else
                begin
                    table_vals[table_len] = qv;
                    table_len++;
                    ans.status = strp_pkg::STATUS_LOADED;
                end
            end
            strp_pkg::CMD_QUERY:
            begin
                for (k = 0; k < table_len; k++)
                begin
                    if (table_vals[k] < qv)
                    begin
                        below++;
                    end
                    else if (table_vals[k] > qv)
                    begin
                        above++;
                    end
                end
                ans.status    = strp_pkg::STATUS_ANSWER;
                ans.below     = below[strp_pkg::CNT_W-1:0];
                ans.above     = above[strp_pkg::CNT_W-1:0];
                ans.benefit   = strp_pkg::BENEFIT_W'(below * above);
                ans.batch_end = fin;
            end
            strp_pkg::CMD_CLEAR:
            begin
                table_len  = 0;
                ans.status = strp_pkg::STATUS_CLEARD;
            end
            default:
            begin
                return 1'b0;
            end
        endcase
        return 1'b1;
    endfunction

    task automatic send_item(input logic [1:0] cmd, input logic [31:0] value, input logic fin);
        rank_answer_t ans;
        while ($urandom_range(99, 0) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= value;
        s_tlast  <= fin;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        if (predict_answer(cmd, value, fin, ans))
        begin
            pending_answers.push_back(ans);
        end
        items_sent++;
    endtask

    // Receiver: random stalls, plus one long hold-off when a test asks for it.
    initial
    begin
        int hold_left;
        hold_left = 0;
        m_tready  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin : check_results
        rank_answer_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_answers.size() == 0)
            begin
                $error("unexpected result transfer: status %0d, data %h", m_tuser, m_tdata);
                error_count++;
            end
            else
            begin
                want = pending_answers.pop_front();
                if (m_tuser !== want.status)
                begin
                    $error("status mismatch: expected %0d, actual %0d", want.status, m_tuser);
                    error_count++;
                end
                if (m_tdata[8:0] !== want.below)
                begin
                    $error("below_count mismatch: expected %0d, actual %0d",
                           want.below, m_tdata[8:0]);
                    error_count++;
                end
                if (m_tdata[17:9] !== want.above)
                begin
                    $error("above_count mismatch: expected %0d, actual %0d",
                           want.above, m_tdata[17:9]);
                    error_count++;
                end
                if (m_tdata[32:18] !== want.benefit)
                begin
                    $error("benefit mismatch: expected %0d, actual %0d",
                           want.benefit, m_tdata[32:18]);
                    error_count++;
                end
                if (m_tlast !== want.batch_end)
                begin
                    $error("batch_end mismatch: expected %0d, actual %0d",
                           want.batch_end, m_tlast);
                    error_count++;
                end
            end
        end
    end

    function automatic logic [31:0] clamp_value(input longint v);
        if (v > 64'sd2147483647)
        begin
            return 32'h7FFF_FFFF;
        end
        if (v < -64'sd2147483648)
        begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic logic [31:0] pick_query_value();
        int     r;
        longint base;
        r = $urandom_range(9, 0);
        if (table_len == 0 || r == 6 || r == 7)
        begin
            return $urandom();
        end
        if (r == 8)
        begin
            return 32'h8000_0000;
        end
        if (r == 9)
        begin
            return 32'h7FFF_FFFF;
        end
        base = table_vals[$urandom_range(table_len - 1, 0)];
        return clamp_value(base + $urandom_range(2, 0) - 1);
    endfunction

    task automatic test_directed();
        send_item(strp_pkg::CMD_QUERY, 32'd0, 1'b1);
        send_item(strp_pkg::CMD_QUERY, 32'h8000_0000, 1'b0);
        send_item(strp_pkg::CMD_LOAD, 32'h8000_0000, 1'b0);
        send_item(strp_pkg::CMD_LOAD, 32'hFFFF_FFFF, 1'b1);
        send_item(strp_pkg::CMD_LOAD, 32'd0, 1'b0);
        send_item(strp_pkg::CMD_LOAD, 32'd0, 1'b0);
        send_item(strp_pkg::CMD_LOAD, 32'd5, 1'b0);
        send_item(strp_pkg::CMD_LOAD, 32'h7FFF_FFFF, 1'b0);
        send_item(strp_pkg::CMD_QUERY, 32'd0, 1'b0);
        send_item(strp_pkg::CMD_QUERY, 32'h8000_0000, 1'b0);
        send_item(strp_pkg::CMD_QUERY, 32'h7FFF_FFFF, 1'b0);
        send_item(strp_pkg::CMD_QUERY, 32'h8000_0001, 1'b0);
        send_item(strp_pkg::CMD_QUERY, 32'd3, 1'b1);
        send_item(CMD_UNUSED, 32'hFFFF_FFFF, 1'b1);
        send_item(strp_pkg::CMD_LOAD, 32'd7, 1'b0);
        send_item(strp_pkg::CMD_QUERY, 32'd6, 1'b1);
        send_item(strp_pkg::CMD_CLEAR, 32'hFFFF_FFFF, 1'b1);
        send_item(strp_pkg::CMD_QUERY, 32'd0, 1'b1);
    endtask

    // Evenly spaced entries let a query land exactly in the middle of a full table.
    task automatic test_full_table();
        int k;
        send_item(strp_pkg::CMD_CLEAR, 32'd0, 1'b0);
        for (k = 0; k < strp_pkg::TABLE_DEPTH; k++)
        begin
            send_item(strp_pkg::CMD_LOAD, 32'(k * 4 - 512), 1'b0);
        end
        send_item(strp_pkg::CMD_LOAD, 32'd1, 1'b0);
        send_item(strp_pkg::CMD_LOAD, 32'h8000_0000, 1'b1);
        send_item(strp_pkg::CMD_QUERY, -32'sd2, 1'b0);
        send_item(strp_pkg::CMD_QUERY, -32'sd1000, 1'b0);
        send_item(strp_pkg::CMD_QUERY, 32'd2000, 1'b0);
        send_item(strp_pkg::CMD_QUERY, -32'sd512, 1'b1);
    endtask

    task automatic test_backpressure();
        int k;
        send_item(strp_pkg::CMD_CLEAR, 32'd0, 1'b0);
        hold_request = LONG_HOLD;
        for (k = 0; k < 12; k++)
        begin
            if (k % 3 == 2)
            begin
                send_item(strp_pkg::CMD_QUERY, $urandom(), k == 11);
            end
            else
            begin
                send_item(strp_pkg::CMD_LOAD, $urandom(), 1'b0);
            end
        end
    endtask

    task automatic send_sorted_run();
        int     n_entries;
        int     n_queries;
        int     span;
        int     k;
        longint cur;
        if ($urandom_range(9, 0) == 0)
        begin
            n_entries = $urandom_range(strp_pkg::TABLE_DEPTH + 2, 200);
        end
        else
        begin
            n_entries = $urandom_range(24, 0);
        end
        case ($urandom_range(2, 0))
            0:       span = 3;
            1:       span = 1000;
            default: span = 1 << 24;
        endcase
        n_queries = $urandom_range(8, 1);
        cur = longint'(signed'($urandom()));
        send_item(strp_pkg::CMD_CLEAR, $urandom(), $urandom_range(1, 0));
        for (k = 0; k < n_entries; k++)
        begin
            send_item(strp_pkg::CMD_LOAD, clamp_value(cur), $urandom_range(1, 0));
            cur = cur + $urandom_range(span, 0);
        end
        for (k = 0; k < n_queries; k++)
        begin
            send_item(strp_pkg::CMD_QUERY, pick_query_value(), k == n_queries - 1);
        end
    endtask

    task automatic send_noise();
        int k;
        int n;
        n = $urandom_range(6, 1);
        for (k = 0; k < n; k++)
        begin
            send_item(2'($urandom_range(3, 0)), $urandom(), $urandom_range(1, 0));
        end
    endtask

    task automatic test_random(input int quota);
        int start;
        start = items_sent;
        while (items_sent - start < quota)
        begin
            if ($urandom_range(4, 0) == 0)
            begin
                send_noise();
            end
            else
            begin
                send_sorted_run();
            end
        end
    endtask

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        s_tuser  = strp_pkg::CMD_LOAD;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 15;
        recv_idle_pct = 76;
        test_directed();
        test_full_table();
        test_backpressure();
        test_random(ITEMS_PER_PHASE);

        send_idle_pct = 76;
        recv_idle_pct = 15;
        test_random(ITEMS_PER_PHASE);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(ITEMS_PER_PHASE);

        s_tvalid <= 1'b0;
        while (pending_answers.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0 && pending_answers.size() == 0)
        begin
            $display("sorted_table_rank_product_tb: PASS");
        end
        else
        begin
            $display("sorted_table_rank_product_tb: FAIL");
        end
        $finish;
    end

endmodule
